/* rtl/jos_pkg.sv */
// Shared types and constants for the Josephus elimination core.
// No dependencies; used by jos_out, jos_ctrl and the top level.
package jos_pkg;

  localparam int MAX_MEMBERS_DEF = 64;
  localparam int STEP_BITS_DEF   = 16;

  localparam int COUNT_W = 7;   // member_count and position field width
  localparam int STEP_W  = 16;  // step_size field width

  typedef struct packed {
    logic [COUNT_W-1:0] member_count;
    logic [STEP_W-1:0]  step_size;
    logic               emit_order;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] position;
    logic               is_survivor;
    logic               last;
  } out_word_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic      push;
    out_word_t word;
  } push_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_LINK,
    S_DONE,
    S_BAD
  } state_e;

endpackage

/* rtl/jos_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module jos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/jos_out.sv */
// Output word register for the Josephus core; accepts a new word while the
// held one is being taken. Depends on jos_pkg.
module jos_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jos_pkg::push_t      push_i,
  output logic                slot_free_o,
  output logic                out_valid_o,
  output jos_pkg::out_word_t  out_word_o,
  input  logic                out_stall_i
);

  logic               valid_q, valid_d;
  jos_pkg::out_word_t word_q;

  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (slot_free_o) begin
      valid_d = push_i.push;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free_o && push_i.push) begin
      word_q <= push_i.word;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

/* rtl/jos_ctrl.sv */
// Sequencer for the Josephus core: ring fill, link walk and removal, all
// through the link RAM. Depends on jos_pkg.
module jos_ctrl #(
  parameter int MAX_MEMBERS = jos_pkg::MAX_MEMBERS_DEF,
  parameter int STEP_BITS   = jos_pkg::STEP_BITS_DEF,
  localparam int IW = $clog2(MAX_MEMBERS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  jos_pkg::in_word_t in_word_i,
  output logic              in_stall_o,
  output jos_pkg::push_t    push_o,
  input  logic              slot_free_i,
  output logic              ram_we_o,
  output logic [IW-1:0]     ram_waddr_o,
  output logic [IW-1:0]     ram_wdata_o,
  output logic              ram_re_o,
  output logic [IW-1:0]     ram_raddr_o,
  input  logic [IW-1:0]     ram_rdata_i
);

  localparam int CW = jos_pkg::COUNT_W;
  localparam int SW = jos_pkg::STEP_W;
  localparam logic [SW-1:0] KMASK =
    (STEP_BITS >= SW) ? {SW{1'b1}} : SW'((64'd1 << STEP_BITS) - 64'd1);

  jos_pkg::state_e state_q, state_d;
  logic [CW-1:0] n_q, n_d, rem_q, rem_d;
  logic [SW-1:0] k_q, k_d, walk_q, walk_d;
  logic          emit_q, emit_d;
  logic [IW-1:0] fill_q, fill_d, cur_q, cur_d, prev_q, prev_d;

  logic [SW-1:0] k_in;
  logic [CW-1:0] fill_nx;
  logic          bad_in;

  assign k_in    = in_word_i.step_size & KMASK;
  assign bad_in  = (in_word_i.member_count == '0) || (k_in == '0) ||
                   (int'(in_word_i.member_count) > MAX_MEMBERS);
  assign fill_nx = CW'(fill_q) + CW'(1);

  assign in_stall_o = (state_q != jos_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    k_d     = k_q;
    emit_d  = emit_q;
    fill_d  = fill_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    rem_d   = rem_q;
    walk_d  = walk_q;
    push_o  = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = fill_q;
    ram_wdata_o = (fill_nx < n_q) ? fill_nx[IW-1:0] : '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = cur_q;

    case (state_q)
      jos_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (bad_in) begin
            state_d = jos_pkg::S_BAD;
          end else begin
            n_d     = in_word_i.member_count;
            k_d     = k_in;
            emit_d  = in_word_i.emit_order;
            fill_d  = '0;
            state_d = jos_pkg::S_FILL;
          end
        end
      end
      jos_pkg::S_FILL: begin
        ram_we_o = 1'b1;
        if (fill_nx == n_q) begin
          cur_d   = '0;
          prev_d  = IW'(n_q - CW'(1));
          rem_d   = n_q;
          walk_d  = SW'(1);
          state_d = (n_q == CW'(1)) ? jos_pkg::S_DONE : jos_pkg::S_READ;
        end else begin
          fill_d = fill_q + IW'(1);
        end
      end
      jos_pkg::S_READ: begin
        ram_re_o = 1'b1;
        state_d  = jos_pkg::S_LINK;
      end
      jos_pkg::S_LINK: begin
        if (walk_q < k_q) begin
          prev_d  = cur_q;
          cur_d   = ram_rdata_i;
          walk_d  = walk_q + SW'(1);
          state_d = jos_pkg::S_READ;
        end else if (!emit_q || slot_free_i) begin
          // cur_q is removed: unlink it behind prev_q
          push_o.push             = emit_q;
          push_o.word.position    = CW'(cur_q) + CW'(1);
          push_o.word.is_survivor = 1'b0;
          push_o.word.last        = 1'b0;
          ram_we_o    = 1'b1;
          ram_waddr_o = prev_q;
          ram_wdata_o = ram_rdata_i;
          cur_d   = ram_rdata_i;
          rem_d   = rem_q - CW'(1);
          walk_d  = SW'(1);
          state_d = (rem_q == CW'(2)) ? jos_pkg::S_DONE : jos_pkg::S_READ;
        end
      end
      jos_pkg::S_DONE: begin
        if (slot_free_i) begin
          push_o.push             = 1'b1;
          push_o.word.position    = CW'(cur_q) + CW'(1);
          push_o.word.is_survivor = 1'b1;
          push_o.word.last        = 1'b1;
          state_d = jos_pkg::S_IDLE;
        end
      end
      jos_pkg::S_BAD: begin
        if (slot_free_i) begin
          push_o.push             = 1'b1;
          push_o.word.position    = '0;
          push_o.word.is_survivor = 1'b1;
          push_o.word.last        = 1'b1;
          state_d = jos_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = jos_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jos_pkg::S_IDLE;
      cur_q   <= '0;
      prev_q  <= '0;
      rem_q   <= '0;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      rem_q   <= rem_d;
      walk_q  <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    k_q    <= k_d;
    emit_q <= emit_d;
    fill_q <= fill_d;
  end

endmodule

/* rtl/josephus_elimination_core.sv */
// Top level of the Josephus elimination core: sequencer, link RAM and output
// register. Depends on jos_pkg, jos_ram, jos_out and jos_ctrl.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+--------------------------------------
//   in      | input     | in_valid_i/in_stall_o | member_count, step_size, emit_order
//   out     | output    | out_valid_o/out_stall_i | position, is_survivor, last
//
// One item at a time. The ring fill writes one link per cycle, then each walk
// step and each removal is a read of the link RAM (S_READ) followed by S_LINK,
// which uses the data; an emitted removal and the survivor wait for the output.
// An invalid item (n or k zero, n above MAX_MEMBERS) goes straight to S_BAD.
// Reset clears the sequencer and the output valid; the link RAM needs no clearing,
// each item writes its ring before reading it. A stalled output holds the
// sequencer only where it has a word to hand over.
module josephus_elimination_core #(
  parameter int MAX_MEMBERS = jos_pkg::MAX_MEMBERS_DEF,
  parameter int STEP_BITS   = jos_pkg::STEP_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  jos_pkg::in_word_t  in_word_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output jos_pkg::out_word_t out_word_o,
  input  logic               out_stall_i
);

  localparam int IW = $clog2(MAX_MEMBERS);

  jos_pkg::push_t push;
  logic           slot_free;

  // link RAM port signals
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  jos_ctrl #(
    .MAX_MEMBERS(MAX_MEMBERS),
    .STEP_BITS  (STEP_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .slot_free_i(slot_free),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  // next_link ring, 0-based member indexes
  jos_ram #(
    .WIDTH(IW),
    .DEPTH(MAX_MEMBERS)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  jos_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .slot_free_o(slot_free),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o),
    .out_stall_i(out_stall_i)
  );

  // An accepted word always keeps the sequencer busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted but sequencer idle next cycle");

  // Reads and writes of the link RAM are sequenced, never on one entry at once.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("link RAM read and write to the same entry");

  // A pushed word is only ever a survivor or a removal, and a removal never ends an item.
  a_removal_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.push && slot_free && !push.word.is_survivor) |-> !push.word.last)
    else $error("removed position marked last");

  // Nothing is pushed while the sequencer is idle.
  a_idle_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !push.push)
    else $error("result pushed from idle");

endmodule
